/* hw/rtl/edlim_pkg.sv */
// ----------------------------------------------------------------------------
// edlim_pkg
// Shared types and constants for the edit distance with limit unit: command
// codes, result widths and the control/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package edlim_pkg;

  // Input command codes
  localparam logic [1:0] CMD_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] CMD_APPEND_SECOND = 2'd1;
  localparam logic [1:0] CMD_COMPUTE       = 2'd2;

  // Fixed port widths
  localparam int CMD_W    = 2;
  localparam int SYM_IN_W = 8;
  localparam int DIST_W   = 7;

  // Reported distance saturates here
  localparam logic [DIST_W-1:0] DIST_MAX = 7'd127;

  // Controller -> datapath commands
  typedef struct packed {
    logic load_first;   // append symbol to first string
    logic load_second;  // append symbol to second string
    logic row_begin;    // start a DP row: fetch first-string symbol, seed left/diag
    logic row_init;     // with row_begin: this is row 1 (base 0)
    logic cell_issue;   // read the above cell and second-string symbol for column j
    logic emit;         // capture result, clear lengths and overflow flag
  } edlim_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic first_empty;
    logic second_empty;
    logic col_last;     // current column is the last one
    logic row_last;     // current row is the last one
  } edlim_status_t;

endpackage

/* hw/rtl/edlim_dpath.sv */
// ----------------------------------------------------------------------------
// edlim_dpath
// Datapath: string buffers, DP row buffer, row/column counters, one-cell
// min-of-three update per cycle, limit register and result registers.
// ----------------------------------------------------------------------------
module edlim_dpath
  import edlim_pkg::*;
#(
  parameter int MAX_LEN     = 64,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  edlim_cmd_t          ctl,
  output edlim_status_t       sts,
  input  logic [SYM_IN_W-1:0] symbol,
  input  logic                cfg_wr_en,
  input  logic [DIST_W-1:0]   cfg_wr_data,
  output logic [DIST_W-1:0]   distance,
  output logic                within_limit,
  output logic                overflowed
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SYM_W = (SYMBOL_BITS < SYM_IN_W) ? SYMBOL_BITS : SYM_IN_W;
  localparam int CW    = (LEN_W > DIST_W) ? LEN_W : DIST_W;

  // Storage
  logic [SYM_W-1:0] first_mem  [MAX_LEN];
  logic [SYM_W-1:0] second_mem [MAX_LEN];
  logic [LEN_W-1:0] dp_mem     [MAX_LEN+1];

  logic [SYM_W-1:0] a_sym;       // first-string symbol of current row
  logic [SYM_W-1:0] b_sym;       // second-string symbol of column in flight
  logic [LEN_W-1:0] above_rd;    // dp row read data

  // Control and datapath registers
  logic [LEN_W-1:0]  len1, len2;
  logic              ovf;
  logic [DIST_W-1:0] max_distance;
  logic [LEN_W-1:0]  row_i;
  logic [LEN_W-1:0]  col_j;
  logic [LEN_W-1:0]  col_q;
  logic              cell_vld;
  logic              first_row;
  logic [LEN_W-1:0]  left, diag, res;

  logic [LEN_W-1:0] base;
  logic [LEN_W-1:0] above;
  logic [LEN_W:0]   up1, left1, diag1, m1, m2;
  logic [LEN_W-1:0] cell_new;
  logic [LEN_W-1:0] dist_raw;
  logic [CW-1:0]    dist_ext;

  // Row base: 0 for the first row, else the row just finished
  assign base = ctl.row_init ? '0 : row_i;

  // First string buffer
  always_ff @(posedge clk) begin
    if (ctl.load_first && len1 != LEN_W'(MAX_LEN)) begin
      first_mem[len1[AW-1:0]] <= symbol[SYM_W-1:0];
    end
    if (ctl.row_begin) begin
      a_sym <= first_mem[base[AW-1:0]];
    end
  end

  // Second string buffer
  always_ff @(posedge clk) begin
    if (ctl.load_second && len2 != LEN_W'(MAX_LEN)) begin
      second_mem[len2[AW-1:0]] <= symbol[SYM_W-1:0];
    end
    if (ctl.cell_issue) begin
      b_sym <= second_mem[AW'(col_j - 1'b1)];
    end
  end

  // DP row buffer: write column in flight, read next column
  always_ff @(posedge clk) begin
    if (cell_vld) begin
      dp_mem[col_q] <= cell_new;
    end
    if (ctl.cell_issue) begin
      above_rd <= dp_mem[col_j];
    end
  end

  // Cell update: min(above+1, left+1, diag+cost)
  always_comb begin
    above = first_row ? col_q : above_rd;
    up1   = {1'b0, above} + 1'b1;
    left1 = {1'b0, left} + 1'b1;
    diag1 = {1'b0, diag} + {{LEN_W{1'b0}}, (a_sym != b_sym)};
    m1    = (up1 < left1) ? up1 : left1;
    m2    = (m1 < diag1) ? m1 : diag1;
    cell_new = m2[LEN_W-1:0];
  end

  // Lengths, overflow flag, limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      len1         <= '0;
      len2         <= '0;
      ovf          <= 1'b0;
      max_distance <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_distance <= cfg_wr_data;
      end
      if (ctl.emit) begin
        len1 <= '0;
        len2 <= '0;
        ovf  <= 1'b0;
      end else begin
        if (ctl.load_first) begin
          if (len1 != LEN_W'(MAX_LEN)) len1 <= len1 + 1'b1;
          else                         ovf  <= 1'b1;
        end
        if (ctl.load_second) begin
          if (len2 != LEN_W'(MAX_LEN)) len2 <= len2 + 1'b1;
          else                         ovf  <= 1'b1;
        end
      end
    end
  end

  // Cell pipeline valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_vld <= 1'b0;
    end else begin
      cell_vld <= ctl.cell_issue;
    end
  end

  // Row/column counters and cell registers
  always_ff @(posedge clk) begin
    if (ctl.cell_issue) begin
      col_q <= col_j;
      col_j <= col_j + 1'b1;
    end
    if (cell_vld) begin
      left <= cell_new;
      diag <= above;
      res  <= cell_new;
    end
    // row seed overrides the last cell's left/diag
    if (ctl.row_begin) begin
      row_i     <= base + 1'b1;
      col_j     <= LEN_W'(1);
      left      <= base + 1'b1;
      diag      <= base;
      first_row <= ctl.row_init;
    end
  end

  // Status
  assign sts.first_empty  = (len1 == '0);
  assign sts.second_empty = (len2 == '0);
  assign sts.col_last     = (col_j == len2);
  assign sts.row_last     = (row_i == len1);

  // Result: an empty string gives the other length
  always_comb begin
    if (len1 == '0)      dist_raw = len2;
    else if (len2 == '0) dist_raw = len1;
    else                 dist_raw = res;
    dist_ext = CW'(dist_raw);
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      distance     <= (dist_ext > CW'(DIST_MAX)) ? DIST_MAX : dist_ext[DIST_W-1:0];
      within_limit <= (dist_ext <= CW'(max_distance));
      overflowed   <= ovf;
    end
  end

endmodule

/* hw/rtl/edlim_ctrl.sv */
// ----------------------------------------------------------------------------
// edlim_ctrl
// Controller: takes input beats, sequences the DP sweep row by row and
// column by column, and hands the result to the output register.
// ----------------------------------------------------------------------------
module edlim_ctrl
  import edlim_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output edlim_cmd_t       ctl,
  input  edlim_status_t    sts
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_START   = 5'b00010,
    ST_CELL    = 5'b00100,
    ST_ROW_END = 5'b01000,
    ST_FINISH  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   in_beat;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_beat) begin
          unique case (cmd)
            CMD_APPEND_FIRST:  ctl.load_first  = 1'b1;
            CMD_APPEND_SECOND: ctl.load_second = 1'b1;
            CMD_COMPUTE: begin
              if (sts.first_empty || sts.second_empty) state_next = ST_FINISH;
              else                                     state_next = ST_START;
            end
            default: ;
          endcase
        end
      end
      ST_START: begin
        ctl.row_begin = 1'b1;
        ctl.row_init  = 1'b1;
        state_next    = ST_CELL;
      end
      ST_CELL: begin
        ctl.cell_issue = 1'b1;
        if (sts.col_last) state_next = ST_ROW_END;
      end
      ST_ROW_END: begin
        // last cell of the row completes here
        if (sts.row_last) begin
          state_next = ST_FINISH;
        end else begin
          ctl.row_begin = 1'b1;
          state_next    = ST_CELL;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          ctl.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.emit)      out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

/* hw/rtl/edit_distance_with_limit_unit.sv */
// ----------------------------------------------------------------------------
// edit_distance_with_limit_unit
// Unit-cost Levenshtein distance between two loaded strings, with a match
// limit check.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, cmd, symbol): cmd 0 appends symbol to
//   the first string, cmd 1 to the second, cmd 2 computes; cmd 3 is ignored.
//   Appends beyond MAX_LEN are dropped and flagged in the next result.
//   A compute beat yields one output beat (distance, within_limit,
//   overflowed) and then clears both strings and the overflow flag.
//   cfg_wr_en/cfg_wr_data write max_distance; write only while idle.
// Sequencing:
//   A compute with lengths n1, n2 (both nonzero) sweeps the DP table row by
//   row through the single cell unit, which updates one DP cell per cycle
//   within a row, with a turnaround state after each row; with an empty
//   string the sweep is skipped and the result goes to the output register.
// Reset (rst, synchronous): strings empty, flag and limit cleared, no
//   output pending.
// Stall: the output register holds the result until out_ready; appends
//   are still taken meanwhile, a further compute runs and then holds the
//   input off until the register frees.
// ----------------------------------------------------------------------------
module edit_distance_with_limit_unit
  import edlim_pkg::*;
#(
  parameter int MAX_LEN     = 64,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [SYM_IN_W-1:0] symbol,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DIST_W-1:0]   distance,
  output logic                within_limit,
  output logic                overflowed,
  input  logic                cfg_wr_en,
  input  logic [DIST_W-1:0]   cfg_wr_data
);

  edlim_cmd_t    ctl;
  edlim_status_t sts;

  // Sequencer
  edlim_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  // Buffers and cell unit
  edlim_dpath #(
    .MAX_LEN     (MAX_LEN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .symbol       (symbol),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .distance     (distance),
    .within_limit (within_limit),
    .overflowed   (overflowed)
  );

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for edit_distance_with_limit_unit. A directed table
// covers the empty, full and overflowing strings and the limit extremes. It
// is followed by random string pairs, mostly near-copies so that the limit
// check goes both ways. Each result beat is compared with the expected value of
// its directed row if given, else an in-bench Levenshtein predictor; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import edlim_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STR_DEPTH      = 64;
  localparam int SYM_BITS       = 8;
  localparam int RANDOM_BEATS   = 180;
  localparam int HOLD_CYCLES    = 400;
  localparam int APPEND_SETTLE  = 4;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SHOWN_ERRORS   = 10;

  // cmd 3 has no name in the package: the unit ignores it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              within_limit;
    logic              overflowed;
  } ed_result_t;

  localparam ed_result_t NO_EXP = '0;

  typedef enum logic {ROW_BEAT, ROW_LIMIT} row_kind_t;
  typedef enum int {EDIT_INSERT, EDIT_DELETE, EDIT_SUBST} edit_t;

  // one table row: a beat sent reps times, or a max_distance write
  typedef struct packed {
    row_kind_t           kind;
    logic [CMD_W-1:0]    op;
    logic [SYM_IN_W-1:0] sym;
    logic [6:0]          reps;
    logic [DIST_W-1:0]   limit;
    logic                typed;
    ed_result_t          want;
  } stim_row_t;

  typedef struct packed {
    logic       typed;
    ed_result_t want;
  } offer_tag_t;

  localparam stim_row_t DIRECTED [27] = '{
    '{ROW_LIMIT, CMD_COMPUTE,       8'h00, 7'd0,  7'd0,  1'b0, NO_EXP},
    '{ROW_BEAT,  CMD_COMPUTE,       8'h00, 7'd1,  7'd0,  1'b1, '{7'd0,  1'b1, 1'b0}},
    '{ROW_BEAT,  CMD_UNUSED,        8'hFF, 7'd1,  7'd0,  1'b0, NO_EXP},
    '{ROW_BEAT,  CMD_APPEND_FIRST,  8'h00, 7'd1,  7'd0,  1'b0, NO_EXP},
    '{ROW_BEAT,  CMD_COMPUTE,       8'hFF, 7'd1,  7'd0,  1'b1, '{7'd1,  1'b0, 1'b0}},
    '{ROW_BEAT,  CMD_APPEND_SECOND, 8'hFF, 7'd1,  7'd0,  1'b0, NO_EXP},
    '{ROW_BEAT,  CMD_APPEND_FIRST,  8'hFF, 7'd1,  7'd0,  1'b0, NO_EXP},
    '{ROW_BEAT,  CMD_COMPUTE,       8'h00, 7'd1,  7'd0,  1'b1, '{7'd0,  1'b1, 1'b0}},
    '{ROW_BEAT,  CMD_APPEND_FIRST,  8'hA5, 7'd1,  7'd0,  1'b0, NO_EXP},
    '{ROW_BEAT,  CMD_APPEND_SECOND, 8'h5A, 7'd1,  7'd0,  1'b0, NO_EXP},
    '{ROW_BEAT,  CMD_COMPUTE,       8'h00, 7'd1,  7'd0,  1'b1, '{7'd1,  1'b0, 1'b0}},
    '{ROW_LIMIT, CMD_COMPUTE,       8'h00, 7'd0,  7'd64, 1'b0, NO_EXP},
    '{ROW_BEAT,  CMD_APPEND_FIRST,  8'h00, 7'd65, 7'd0,  1'b0, NO_EXP},
    '{ROW_BEAT,  CMD_APPEND_SECOND, 8'hFF, 7'd66, 7'd0,  1'b0, NO_EXP},
    '{ROW_BEAT,  CMD_COMPUTE,       8'h00, 7'd1,  7'd0,  1'b1, '{7'd64, 1'b1, 1'b1}},
    '{ROW_LIMIT, CMD_COMPUTE,       8'h00, 7'd0,  7'd63, 1'b0, NO_EXP},
    '{ROW_BEAT,  CMD_APPEND_FIRST,  8'h00, 7'd64, 7'd0,  1'b0, NO_EXP},
    '{ROW_BEAT,  CMD_APPEND_SECOND, 8'hFF, 7'd64, 7'd0,  1'b0, NO_EXP},
    '{ROW_BEAT,  CMD_COMPUTE,       8'h00, 7'd1,  7'd0,  1'b1, '{7'd64, 1'b0, 1'b0}},
    '{ROW_LIMIT, CMD_COMPUTE,       8'h00, 7'd0,  7'd1,  1'b0, NO_EXP},
    '{ROW_BEAT,  CMD_APPEND_FIRST,  8'h01, 7'd1,  7'd0,  1'b0, NO_EXP},
    '{ROW_BEAT,  CMD_UNUSED,        8'h02, 7'd1,  7'd0,  1'b0, NO_EXP},
    '{ROW_BEAT,  CMD_APPEND_SECOND, 8'h01, 7'd1,  7'd0,  1'b0, NO_EXP},
    '{ROW_BEAT,  CMD_APPEND_FIRST,  8'h02, 7'd1,  7'd0,  1'b0, NO_EXP},
    '{ROW_BEAT,  CMD_COMPUTE,       8'h00, 7'd1,  7'd0,  1'b0, NO_EXP},
    '{ROW_BEAT,  CMD_APPEND_SECOND, 8'h7E, 7'd1,  7'd0,  1'b0, NO_EXP},
    '{ROW_BEAT,  CMD_COMPUTE,       8'h00, 7'd1,  7'd0,  1'b0, NO_EXP}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    cmd = '0;
  logic [SYM_IN_W-1:0] symbol = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DIST_W-1:0]   distance;
  logic                within_limit;
  logic                overflowed;
  logic                cfg_wr_en = 1'b0;
  logic [DIST_W-1:0]   cfg_wr_data = '0;

  // predictor state
  logic [SYM_IN_W-1:0] str_a [STR_DEPTH];
  logic [SYM_IN_W-1:0] str_b [STR_DEPTH];
  int                  len_a = 0;
  int                  len_b = 0;
  bit                  dropped = 1'b0;
  logic [DIST_W-1:0]   limit_reg = '0;

  offer_tag_t offered_q [$];
  ed_result_t pending_dist_q [$];
  int         mismatch_cnt = 0;
  int         beats_sent = 0;
  int         idle_cycles = 0;
  bit         steady = 1'b0;
  bit         hold_go = 1'b0;

  edit_distance_with_limit_unit #(
    .MAX_LEN     (STR_DEPTH),
    .SYMBOL_BITS (SYM_BITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .symbol       (symbol),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .distance     (distance),
    .within_limit (within_limit),
    .overflowed   (overflowed),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // single-row unit-cost DP over the loaded strings
  function automatic int levenshtein_dist();
    int row [STR_DEPTH+1];
    int diag;
    int above;
    int best;
    for (int j = 0; j <= len_b; j++) row[j] = j;
    for (int i = 1; i <= len_a; i++) begin
      diag = row[0];
      row[0] = i;
      for (int j = 1; j <= len_b; j++) begin
        above = row[j];
        best = diag + int'(str_a[i-1] != str_b[j-1]);
        if (above + 1 < best) best = above + 1;
        if (row[j-1] + 1 < best) best = row[j-1] + 1;
        row[j] = best;
        diag = above;
      end
    end
    return row[len_b];
  endfunction

  // advance the predictor by one accepted beat; 1 when a result is due
  function automatic bit model_beat(input logic [CMD_W-1:0] op,
                                    input logic [SYM_IN_W-1:0] sym,
                                    output ed_result_t res);
    int d;
    res = NO_EXP;
    case (op)
      CMD_APPEND_FIRST: begin
        if (len_a < STR_DEPTH) begin
          str_a[len_a] = sym;
          len_a++;
        end else begin
          dropped = 1'b1;
        end
      end
      CMD_APPEND_SECOND: begin
        if (len_b < STR_DEPTH) begin
          str_b[len_b] = sym;
          len_b++;
        end else begin
          dropped = 1'b1;
        end
      end
      CMD_COMPUTE: begin
        d = levenshtein_dist();
        res.distance     = (d > int'(DIST_MAX)) ? DIST_MAX : DIST_W'(d);
        res.within_limit = (d <= int'(limit_reg));
        res.overflowed   = dropped;
        len_a   = 0;
        len_b   = 0;
        dropped = 1'b0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= SHOWN_ERRORS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // scoreboard: predict on input beats, compare on output beats
  always @(posedge clk) begin : scoreboard
    offer_tag_t tag;
    ed_result_t pred;
    ed_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        tag = offered_q.pop_front();
        if (model_beat(cmd, symbol, pred))
          pending_dist_q.push_back(tag.typed ? tag.want : pred);
      end
      if (out_valid && out_ready) begin
        if (pending_dist_q.size() == 0) begin
          log_mismatch($sformatf(
            "result beat with nothing expected: dist=%0d lim=%0b ovf=%0b",
            distance, within_limit, overflowed));
        end else begin
          want = pending_dist_q.pop_front();
          if (distance !== want.distance || within_limit !== want.within_limit ||
              overflowed !== want.overflowed)
            log_mismatch($sformatf(
              "expected dist=%0d lim=%0b ovf=%0b, got dist=%0d lim=%0b ovf=%0b",
              want.distance, want.within_limit, want.overflowed,
              distance, within_limit, overflowed));
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off, a steady window
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 30);
      end
    end
  end

  task automatic send_beat(input logic [CMD_W-1:0] op, input logic [SYM_IN_W-1:0] sym,
                           input logic typed = 1'b0, input ed_result_t want = NO_EXP);
    if (!steady && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    offered_q.push_back('{typed, want});
    in_valid <= 1'b1;
    cmd      <= op;
    symbol   <= sym;
    do @(posedge clk); while (!in_ready);
    if (op != CMD_UNUSED) beats_sent++;
  endtask

  // max_distance may only change with nothing in flight
  task automatic write_limit(input logic [DIST_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_dist_q.size() != 0) @(posedge clk);
    repeat (APPEND_SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = value;
  endtask

  function automatic int rand_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 4) return $urandom_range(72, 56);
    if (pick < 14) return 0;
    return $urandom_range(8, 1);
  endfunction

  function automatic logic [SYM_IN_W-1:0] rand_sym(input bit wide,
                                                   input logic [SYM_IN_W-1:0] base);
    return wide ? SYM_IN_W'($urandom) : base ^ SYM_IN_W'($urandom_range(3));
  endfunction

  // one string pair, appends interleaved, usually closed by a compute
  task automatic run_pair();
    logic [SYM_IN_W-1:0] a_q [$];
    logic [SYM_IN_W-1:0] b_q [$];
    logic [SYM_IN_W-1:0] base;
    bit                  wide;
    int                  n;
    int                  pos;
    wide = ($urandom_range(99) < 40);
    base = SYM_IN_W'($urandom);
    n = rand_len();
    for (int k = 0; k < n; k++) a_q.push_back(rand_sym(wide, base));
    if ($urandom_range(99) < 15) begin
      n = rand_len();
      for (int k = 0; k < n; k++) b_q.push_back(rand_sym(wide, base));
    end else begin
      // near-copy: a few random edits
      b_q = a_q;
      repeat ($urandom_range(3)) begin
        pos = $urandom_range(b_q.size());
        case (edit_t'($urandom_range(2)))
          EDIT_INSERT: b_q.insert(pos, rand_sym(wide, base));
          EDIT_DELETE: if (pos < b_q.size()) b_q.delete(pos);
          default:     if (pos < b_q.size()) b_q[pos] = rand_sym(wide, base);
        endcase
      end
    end
    while (a_q.size() + b_q.size() != 0) begin
      if ($urandom_range(99) < 4) send_beat(CMD_UNUSED, SYM_IN_W'($urandom));
      if (b_q.size() == 0 || (a_q.size() != 0 && $urandom_range(1) == 1))
        send_beat(CMD_APPEND_FIRST, a_q.pop_front());
      else
        send_beat(CMD_APPEND_SECOND, b_q.pop_front());
    end
    // an unterminated pair carries its strings into the next one
    if ($urandom_range(99) < 90) send_beat(CMD_COMPUTE, SYM_IN_W'($urandom));
  endtask

  // stimulus: directed table, then random pairs in limit phases
  initial begin : stimulus
    int                pairs;
    int                start_beats;
    logic [DIST_W-1:0] lim;
    while (rst) @(posedge clk);

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_LIMIT) begin
        write_limit(DIRECTED[r].limit);
      end else begin
        for (int k = 0; k < DIRECTED[r].reps; k++)
          send_beat(DIRECTED[r].op, DIRECTED[r].sym, DIRECTED[r].typed, DIRECTED[r].want);
      end
    end

    start_beats = beats_sent;
    pairs = 0;
    while (beats_sent - start_beats < RANDOM_BEATS) begin
      if (pairs % 6 == 0) begin
        case ($urandom_range(3))
          0:       lim = 7'd0;
          1:       lim = 7'd64;
          2:       lim = DIST_W'($urandom_range(64));
          default: lim = DIST_W'($urandom_range(4));
        endcase
        write_limit(lim);
        // first phase: long output hold while inputs keep coming
        if (pairs == 0) hold_go = 1'b1;
      end
      steady = (pairs >= 4 && pairs < 10);
      run_pair();
      pairs++;
    end
    steady = 1'b0;

    // drain
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_dist_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_dist_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
